@@ rtl/ftlb_pkg.sv @@
// ----------------------------------------------------------------------------
// ftlb_pkg
// Types and codes shared by the FIFO translation buffer and its cells.
// ----------------------------------------------------------------------------
package ftlb_pkg;

   localparam int ACTION_W = 2;
   localparam int PID_W    = 8;
   localparam int PAGE_W   = 12;
   localparam int FRAME_W  = 12;
   localparam int ACTIVE_W = 5;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

   localparam logic [ACTION_W-1:0] ACT_LOOKUP    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_INSERT    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FLUSH_PID = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_FLUSH_ALL = 2'd3;

   localparam int CELL_OP_W = 3;
   localparam logic [CELL_OP_W-1:0] CELL_HOLD    = 3'd0;
   localparam logic [CELL_OP_W-1:0] CELL_APPEND  = 3'd1;
   localparam logic [CELL_OP_W-1:0] CELL_SHIFT   = 3'd2;
   localparam logic [CELL_OP_W-1:0] CELL_MARK    = 3'd3;
   localparam logic [CELL_OP_W-1:0] CELL_COMPACT = 3'd4;
   localparam logic [CELL_OP_W-1:0] CELL_CLEAR   = 3'd5;

   typedef struct packed {
      logic               valid;
      logic [PID_W-1:0]   pid;
      logic [PAGE_W-1:0]  page;
      logic [FRAME_W-1:0] frame;
   } entry_type;

   typedef struct packed {
      logic [CELL_OP_W-1:0] op;
      logic [PID_W-1:0]     pid;
      logic [PAGE_W-1:0]    page;
      logic [FRAME_W-1:0]   frame;
   } cell_cmd_type;

   typedef struct packed {
      logic               prev_valid;
      logic               hole_seen;
      logic               found;
      logic [FRAME_W-1:0] frame;
   } cell_chain_type;

endpackage

@@ rtl/ftlb_cell.sv @@
// ----------------------------------------------------------------------------
// ftlb_cell
// One slot of the translation buffer: holds an entry, compares it, and takes
// its neighbor's entry when the row shifts toward the oldest end.
// ----------------------------------------------------------------------------
module ftlb_cell
   import ftlb_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  cell_cmd_type     cmd,
   input  logic [IDX_W-1:0] last_idx,
   input  entry_type        upper,
   input  cell_chain_type   chain_in,
   output cell_chain_type   chain_out,
   output entry_type        entry
);

   entry_type entry_ff;
   entry_type entry_in;
   entry_type new_entry;
   logic      match;
   logic      is_last;
   logic      below_last;

   assign is_last    = (last_idx == IDX_W'(INDEX));
   assign below_last = (IDX_W'(INDEX) < last_idx);
   assign match      = entry_ff.valid && (entry_ff.pid == cmd.pid) &&
                       (entry_ff.page == cmd.page);

   always_comb begin
      new_entry.valid = 1'b1;
      new_entry.pid   = cmd.pid;
      new_entry.page  = cmd.page;
      new_entry.frame = cmd.frame;
   end

   always_comb begin
      chain_out.prev_valid = entry_ff.valid;
      chain_out.hole_seen  = chain_in.hole_seen | ~entry_ff.valid;
      chain_out.found      = chain_in.found | match;
      if (chain_in.found) begin
         chain_out.frame = chain_in.frame;
      end else if (match) begin
         chain_out.frame = entry_ff.frame;
      end else begin
         chain_out.frame = '0;
      end
   end

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_APPEND: begin
            if (!entry_ff.valid && chain_in.prev_valid) begin
               entry_in = new_entry;
            end
         end
         CELL_SHIFT: begin
            if (is_last) begin
               entry_in = new_entry;
            end else if (below_last) begin
               entry_in = upper;
            end
         end
         CELL_MARK: begin
            if (entry_ff.valid && (entry_ff.pid == cmd.pid)) begin
               entry_in.valid = 1'b0;
            end
         end
         CELL_COMPACT: begin
            if (chain_in.hole_seen || !entry_ff.valid) begin
               entry_in = upper;
            end
         end
         CELL_CLEAR: begin
            entry_in.valid = 1'b0;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.pid   <= entry_in.pid;
      entry_ff.page  <= entry_in.page;
      entry_ff.frame <= entry_in.frame;
   end

   assign entry = entry_ff;

endmodule

@@ rtl/fifo_tlb_with_process_flush_core.sv @@
// ----------------------------------------------------------------------------
// fifo_tlb_with_process_flush_core
// Fully associative translation buffer with first-in-first-out replacement,
// built as a row of slot cells kept in age order.
// ----------------------------------------------------------------------------
// Lookup, insert and flush-all items: the result appears in the cycle after
// start, and a new item may be started in every cycle while busy is low.
// A flush of one process marks its entries invalid and holds busy high until no
// free slot lies below the newest surviving entry; the row closes one slot a cycle.
// Reset is synchronous: all slots become invalid and active_entries is 16.
// The receiver cannot stall; every result is shown for one cycle on rsp_valid.
// ----------------------------------------------------------------------------
module fifo_tlb_with_process_flush_core
   import ftlb_pkg::*;
#(
   parameter int TLB_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [PID_W-1:0]    req_pid,
   input  logic [PAGE_W-1:0]   req_page,
   input  logic [FRAME_W-1:0]  req_frame,
   output logic                rsp_valid,
   output logic                rsp_hit,
   output logic [FRAME_W-1:0]  rsp_frame_out,
   output logic                rsp_evicted,
   input  logic                csr_write_enable,
   input  logic [ACTIVE_W-1:0] csr_write_data
);

   localparam int IDX_W = $clog2(TLB_DEPTH);
   localparam int CNT_W = $clog2(TLB_DEPTH + 1);
   localparam int CMP_W = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;

   logic [ACTIVE_W-1:0] active_ff;
   logic                busy_ff;
   logic                busy_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                hit_ff;
   logic                hit_in;
   logic [FRAME_W-1:0]  frame_ff;
   logic [FRAME_W-1:0]  frame_in;
   logic                evicted_ff;
   logic                evicted_in;

   logic [CMP_W-1:0]     active_ext;
   logic [IDX_W-1:0]     last_idx;
   logic                 accept;
   logic                 full;
   logic                 gap;
   logic [TLB_DEPTH-1:0] valid_vec;
   cell_cmd_type         cmd;
   cell_chain_type       chain [TLB_DEPTH+1];
   entry_type            entries [TLB_DEPTH];
   entry_type            empty_entry;

   assign accept = start && !busy_ff;

   assign active_ext = CMP_W'(active_ff);
   always_comb begin
      if (active_ext == '0) begin
         last_idx = '0;
      end else if (active_ext > CMP_W'(TLB_DEPTH)) begin
         last_idx = IDX_W'(TLB_DEPTH - 1);
      end else begin
         last_idx = IDX_W'(active_ext - CMP_W'(1));
      end
   end

   always_comb begin
      for (int i = 0; i < TLB_DEPTH; i++) begin
         valid_vec[i] = entries[i].valid;
      end
   end

   assign full = valid_vec[last_idx];
   assign gap  = |(~valid_vec[TLB_DEPTH-2:0] & valid_vec[TLB_DEPTH-1:1]);

   always_comb begin
      cmd.pid   = req_pid;
      cmd.page  = req_page;
      cmd.frame = req_frame;
      cmd.op    = CELL_HOLD;
      if (csr_write_enable) begin
         cmd.op = CELL_CLEAR;
      end else if (accept) begin
         case (req_action)
            ACT_LOOKUP:    cmd.op = CELL_HOLD;
            ACT_INSERT:    cmd.op = full ? CELL_SHIFT : CELL_APPEND;
            ACT_FLUSH_PID: cmd.op = CELL_MARK;
            ACT_FLUSH_ALL: cmd.op = CELL_CLEAR;
            default:       cmd.op = CELL_HOLD;
         endcase
      end else if (busy_ff && gap) begin
         cmd.op = CELL_COMPACT;
      end
   end

   assign empty_entry = '0;
   assign chain[0]    = '{prev_valid: 1'b1, hole_seen: 1'b0, found: 1'b0, frame: '0};

   for (genvar g = 0; g < TLB_DEPTH; g++) begin : g_cell
      ftlb_cell #(
         .INDEX (g),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .last_idx  (last_idx),
         .upper     ((g == TLB_DEPTH - 1) ? empty_entry : entries[(g + 1) % TLB_DEPTH]),
         .chain_in  (chain[g]),
         .chain_out (chain[g+1]),
         .entry     (entries[g])
      );
   end

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      hit_in       = 1'b0;
      frame_in     = '0;
      evicted_in   = 1'b0;
      if (accept) begin
         if (req_action == ACT_FLUSH_PID) begin
            busy_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b1;
         end
         if (req_action == ACT_LOOKUP) begin
            hit_in   = chain[TLB_DEPTH].found;
            frame_in = chain[TLB_DEPTH].frame;
         end
         if (req_action == ACT_INSERT) begin
            evicted_in = full;
         end
      end else if (busy_ff && !gap) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= ACTIVE_RESET;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            active_ff <= csr_write_data;
         end
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hit_ff     <= hit_in;
      frame_ff   <= frame_in;
      evicted_ff <= evicted_in;
   end

   assign busy          = busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = hit_ff;
   assign rsp_frame_out = frame_ff;
   assign rsp_evicted   = evicted_ff;

endmodule
